// ----- hdl/wmpc_pkg.sv -----
// Shared types and constants for the windowed mismatch placement check.
`default_nettype none
package wmpc_pkg;

	localparam int MaxMisW   = 6;
	localparam int QualW     = 8;
	localparam int CfgDataW  = 8;
	localparam int CfgAddrW  = 1;

	localparam logic [CfgAddrW-1:0] CFG_MAX_WINDOW_MISMATCHES = 1'd0;
	localparam logic [CfgAddrW-1:0] CFG_TRUSTED_QUALITY       = 1'd1;

	localparam logic [MaxMisW-1:0] MAX_MIS_RESET = 6'd4;
	localparam logic [QualW-1:0]   TRUSTED_RESET = 8'd30;

	localparam logic [1:0] REASON_PASS      = 2'd0;
	localparam logic [1:0] REASON_TRUSTED   = 2'd1;
	localparam logic [1:0] REASON_SHORT     = 2'd2;
	localparam logic [1:0] REASON_NO_WINDOW = 2'd3;

	typedef struct packed {
		logic [1:0]       read_base;
		logic [1:0]       edge_base;
		logic [QualW-1:0] base_quality;
		logic             last_pair;
	} in_item_t;

	typedef struct packed {
		logic       placement_good;
		logic [1:0] fail_reason;
	} out_item_t;

	// Per-transaction flags handed from the front stage to the tally stage
	typedef struct packed {
		logic mis;          // read base differs from edge base
		logic trusted_hit;  // mismatch at or above trusted quality
		logic last;         // final pair of the overlap
		logic short_ovl;    // overlap still shorter than the window
		logic slot_live;    // slot leaving the window was written in this overlap
		logic fwd;          // slot was written in the cycle it was read
		logic fwd_bit;      // value written in that cycle
	} pipe_flags_t;

endpackage
`default_nettype wire

// ----- hdl/windowed_mismatch_placement_check.sv -----
// Windowed mismatch placement check: streams aligned base pairs, gives one verdict per overlap.
//
// Input channel in_valid/in_ready/in_data carries one aligned pair per
// transaction; last_pair closes the overlap. Output channel
// out_valid/out_ready/out_data carries one verdict per overlap, produced
// from the transaction that closed it. Other pairs give no output.
// The closing pair is registered in the front stage, then the tally stage
// registers the verdict and raises out_valid. Throughput: one pair per cycle
// while in_ready is high; the window flags live in a one-bit-wide memory that
// is read when a pair is taken and written back as that pair leaves the tally
// stage, with a bypass when both touch the same slot. A stalled out_ready holds
// a pending verdict in the output register while pairs keep flowing; only when
// the next closing pair reaches the tally stage do both stages hold and in_ready
// drop, and in_ready returns in the cycle the verdict is taken. The user must
// write registers through cfg_we/cfg_addr/cfg_wdata only while the block is
// idle; the block does not enforce this. Reset restores the register defaults
// (limit 4, trusted quality 30) and empties the window; the memory needs no
// clearing pass since only slots written in the current overlap are ever counted.
`default_nettype none
module windowed_mismatch_placement_check
	import wmpc_pkg::*;
#(
	parameter int WINDOW_LEN = 60
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_item_t            in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_data,
	input  wire logic                cfg_we,
	input  wire logic [CfgAddrW-1:0] cfg_addr,
	input  wire logic [CfgDataW-1:0] cfg_wdata
);

	localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	logic [MaxMisW-1:0] max_mis_q;
	logic [QualW-1:0]   trusted_qual_q;
	logic               advance;
	logic               accept;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               rd_bit;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic               wr_bit;
	logic               valid_s1;
	pipe_flags_t        flags_s1;

	// hold only when a closing pair would overwrite a waiting verdict
	assign advance  = !(valid_s1 && flags_s1.last) || !out_valid || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mis_q      <= MAX_MIS_RESET;
			trusted_qual_q <= TRUSTED_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MAX_WINDOW_MISMATCHES: max_mis_q      <= cfg_wdata[MaxMisW-1:0];
				CFG_TRUSTED_QUALITY:       trusted_qual_q <= cfg_wdata[QualW-1:0];
				default: ;
			endcase
		end
	end

	wmpc_front #(
		.WINDOW_LEN(WINDOW_LEN),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.advance(advance),
		.item(in_data),
		.trusted_quality(trusted_qual_q),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_bit(wr_bit),
		.valid_s1(valid_s1),
		.flags_s1(flags_s1)
	);

	wmpc_window_mem #(
		.DEPTH(WINDOW_LEN),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_bit),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_bit)
	);

	wmpc_tally #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_tally (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.valid_s1(valid_s1),
		.flags_s1(flags_s1),
		.rd_bit(rd_bit),
		.mis_limit(max_mis_q),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

// ----- hdl/wmpc_window_mem.sv -----
// One-bit-wide mismatch flag memory, one write and one registered read port.
`default_nettype none
module wmpc_window_mem #(
	parameter int DEPTH = 60,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/wmpc_front.sv -----
// Front stage: mismatch detect, ring pointer, pair count and memory read issue.
`default_nettype none
module wmpc_front
	import wmpc_pkg::*;
#(
	parameter int WINDOW_LEN = 60,
	parameter int AW         = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic             advance,
	input  wire in_item_t         item,
	input  wire logic [QualW-1:0] trusted_quality,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output logic                  wr_bit,
	output logic                  valid_s1,
	output pipe_flags_t           flags_s1
);

	localparam int PW = $clog2(WINDOW_LEN + 1);
	localparam logic [PW-1:0] PAIRS_FULL = PW'(WINDOW_LEN);
	localparam logic [AW-1:0] HEAD_LAST  = AW'(WINDOW_LEN - 1);

	logic [AW-1:0] head_q;
	logic [PW-1:0] pairs_q;
	logic [AW-1:0] head_s1;
	logic [PW-1:0] pairs_next;
	logic [AW-1:0] head_next;
	logic          mis;
	logic          proc;

	assign mis        = item.read_base != item.edge_base;
	assign pairs_next = (pairs_q == PAIRS_FULL) ? PAIRS_FULL : pairs_q + PW'(1);
	assign head_next  = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
	assign proc       = valid_s1 && advance;

	assign rd_en   = accept;
	assign rd_addr = head_q;
	assign wr_en   = proc;
	assign wr_addr = head_s1;
	assign wr_bit  = flags_s1.mis;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			pairs_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= accept;
			end
			if (accept) begin
				// restart the ring for the next overlap after the final pair
				if (item.last_pair) begin
					head_q  <= '0;
					pairs_q <= '0;
				end else begin
					head_q  <= head_next;
					pairs_q <= pairs_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_s1              <= head_q;
			flags_s1.mis         <= mis;
			flags_s1.trusted_hit <= mis && (item.base_quality >= trusted_quality);
			flags_s1.last        <= item.last_pair;
			flags_s1.short_ovl   <= pairs_next != PAIRS_FULL;
			flags_s1.slot_live   <= pairs_q == PAIRS_FULL;
			// the read sees old data when the tally stage writes the same slot
			flags_s1.fwd         <= proc && (head_s1 == head_q);
			flags_s1.fwd_bit     <= flags_s1.mis;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/wmpc_tally.sv -----
// Tally stage: running window count, pass and veto flags, verdict register.
`default_nettype none
module wmpc_tally
	import wmpc_pkg::*;
#(
	parameter int WINDOW_LEN = 60
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic               valid_s1,
	input  wire pipe_flags_t        flags_s1,
	input  wire logic               rd_bit,
	input  wire logic [MaxMisW-1:0] mis_limit,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output out_item_t               out_data
);

	localparam int TW = $clog2(WINDOW_LEN + 1);
	localparam int CW = 9;

	logic [TW-1:0] total_q;
	logic          passed_q;
	logic          trusted_q;
	logic          leaving;
	logic [TW-1:0] total_new;
	logic          passed_new;
	logic          trusted_new;
	logic          proc;
	logic [1:0]    reason;

	assign proc        = valid_s1 && advance;
	assign leaving     = flags_s1.slot_live && (flags_s1.fwd ? flags_s1.fwd_bit : rd_bit);
	assign total_new   = total_q - TW'(leaving) + TW'(flags_s1.mis);
	assign passed_new  = passed_q ||
		(!flags_s1.short_ovl && (CW'(total_new) <= CW'(mis_limit)));
	assign trusted_new = trusted_q || flags_s1.trusted_hit;

	always_comb begin
		if (flags_s1.short_ovl) begin
			reason = REASON_SHORT;
		end else if (trusted_new) begin
			reason = REASON_TRUSTED;
		end else if (passed_new) begin
			reason = REASON_PASS;
		end else begin
			reason = REASON_NO_WINDOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			passed_q  <= 1'b0;
			trusted_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// a new verdict only enters when the register is free or being taken
			if (proc && flags_s1.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (proc) begin
				// drop all overlap state once the verdict is out
				if (flags_s1.last) begin
					total_q   <= '0;
					passed_q  <= 1'b0;
					trusted_q <= 1'b0;
				end else begin
					total_q   <= total_new;
					passed_q  <= passed_new;
					trusted_q <= trusted_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && flags_s1.last) begin
			out_data.placement_good <= reason == REASON_PASS;
			out_data.fail_reason    <= reason;
		end
	end

endmodule
`default_nettype wire
